// ===== rtl/core/rfp_pkg.sv =====
// Package for the relocation field patcher: relocation type codes, status codes,
// field masks and small helpers for building the relocated bits.
// Has no dependencies; used by every module of the block and by its checker.
package rfp_pkg;

    typedef enum logic [3:0] {
        MODE_NONE    = 4'd0,
        MODE_ABS32   = 4'd1,
        MODE_PCREL7  = 4'd2,
        MODE_PCREL13 = 4'd3,
        MODE_ABS16   = 4'd4,
        MODE_LO_LDI  = 4'd5,
        MODE_HI_LDI  = 4'd6,
        MODE_HH_LDI  = 4'd7,
        MODE_LO_NEG  = 4'd8,
        MODE_HI_NEG  = 4'd9,
        MODE_HH_NEG  = 4'd10,
        MODE_ABS6    = 4'd11,
        MODE_ADIW6   = 4'd12,
        MODE_ABS8    = 4'd13,
        MODE_UNIMPL  = 4'd14,
        MODE_UNKNOWN = 4'd15
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_UNIMPL  = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    localparam logic [31:0] MASK_PC7  = 32'h0000_03F8;
    localparam logic [31:0] MASK_PC13 = 32'h0000_0FFF;
    localparam logic [31:0] MASK_LDI  = 32'h0000_0F0F;
    localparam logic [31:0] MASK_ABS6 = 32'h0000_2C07;
    localparam logic [31:0] MASK_ADIW = 32'h0000_00CF;
    localparam logic [31:0] MASK_8    = 32'h0000_00FF;
    localparam logic [31:0] MASK_16   = 32'h0000_FFFF;
    localparam logic [31:0] MASK_32   = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [3:0]  mode;
        logic [31:0] instr_word;
        logic [31:0] target_address;
        logic [31:0] addend;
        logic [31:0] place_address;
    } reloc_req_t;

    function automatic logic [31:0] ldi_bits(input logic [7:0] byte_val);
        return {20'd0, byte_val[7:4], 4'd0, byte_val[3:0]};
    endfunction

    function automatic logic [31:0] merge(input logic [31:0] word,
                                          input logic [31:0] val,
                                          input logic [31:0] mask);
        return (word & ~mask) | (val & mask);
    endfunction

endpackage

// ===== rtl/core/reloc_field_patcher_top.sv =====
// Top level of the relocation field patcher: input register, patch unit and
// result register. Depends on rfp_pkg and rfp_patch.
//
// A request is taken on any cycle with start high; busy is never raised, so one
// request per cycle is sustained. Each result is shown with done high for exactly
// one cycle, in request order, after the input register and then the patch adders
// into the result register.
// The receiver must take every result in the cycle it is shown.
module reloc_field_patcher_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [3:0]          mode,
    input  logic [31:0]         instr_word,
    input  logic [31:0]         target_address,
    input  logic signed [31:0]  addend,
    input  logic [31:0]         place_address,
    output logic                done,
    output logic [31:0]         patched_word,
    output logic [1:0]          status
);
    import rfp_pkg::*;

    reloc_req_t  req_reg;
    logic        req_valid_reg;
    logic [31:0] word_next;
    status_t     status_next;
    logic [31:0] word_reg;
    logic [1:0]  status_reg;
    logic        done_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            req_reg <= '{mode: mode, instr_word: instr_word,
                         target_address: target_address,
                         addend: addend, place_address: place_address};
        end
        if (req_valid_reg)
        begin
            word_reg   <= word_next;
            status_reg <= status_next;
        end
    end

    rfp_patch u_patch (
        .req          (req_reg),
        .patched_word (word_next),
        .status       (status_next)
    );

    assign done         = done_reg;
    assign patched_word = word_reg;
    assign status       = status_reg;

endmodule

// ===== rtl/core/rfp_patch.sv =====
// Combinational patch unit: computes the relocated value and merges it into
// the instruction word under the field mask of the relocation type; for an
// unsupported type the word passes unchanged with an error status. Depends on rfp_pkg.
module rfp_patch (
    input  rfp_pkg::reloc_req_t req,
    output logic [31:0]         patched_word,
    output rfp_pkg::status_t    status
);
    import rfp_pkg::*;

    logic [31:0] value;
    logic [31:0] neg_value;
    logic [31:0] diff;
    logic [31:0] disp;

    assign value     = req.target_address + req.addend;
    assign neg_value = 32'd0 - value;
    assign diff      = req.target_address + req.addend - req.place_address - 32'd2;
    assign disp      = {diff[31], diff[31:1]};

    always_comb
    begin
        patched_word = req.instr_word;
        status       = ST_OK;
        unique case (mode_t'(req.mode))
            MODE_NONE:    patched_word = req.instr_word;
            MODE_ABS32:   patched_word = merge(req.instr_word, value, MASK_32);
            MODE_PCREL7:  patched_word = merge(req.instr_word, {disp[28:0], 3'd0}, MASK_PC7);
            MODE_PCREL13: patched_word = merge(req.instr_word, disp, MASK_PC13);
            MODE_ABS16:   patched_word = merge(req.instr_word, value, MASK_16);
            MODE_LO_LDI:  patched_word = merge(req.instr_word, ldi_bits(value[7:0]), MASK_LDI);
            MODE_HI_LDI:  patched_word = merge(req.instr_word, ldi_bits(value[15:8]), MASK_LDI);
            MODE_HH_LDI:  patched_word = merge(req.instr_word, ldi_bits(value[23:16]), MASK_LDI);
            MODE_LO_NEG:
                patched_word = merge(req.instr_word, ldi_bits(neg_value[7:0]), MASK_LDI);
            MODE_HI_NEG:
                patched_word = merge(req.instr_word, ldi_bits(neg_value[15:8]), MASK_LDI);
            MODE_HH_NEG:
                patched_word = merge(req.instr_word, ldi_bits(neg_value[23:16]), MASK_LDI);
            MODE_ABS6:
                patched_word = merge(req.instr_word,
                                     {18'd0, value[5], 1'b0, value[4:3], 7'd0, value[2:0]},
                                     MASK_ABS6);
            MODE_ADIW6:
                patched_word = merge(req.instr_word,
                                     {24'd0, value[5:4], 2'd0, value[3:0]}, MASK_ADIW);
            MODE_ABS8:    patched_word = merge(req.instr_word, value, MASK_8);
            MODE_UNIMPL:  status = ST_UNIMPL;
            MODE_UNKNOWN: status = ST_UNKNOWN;
            default:      status = ST_UNKNOWN;
        endcase
    end

endmodule

// ===== rtl/core/rfp_checker.sv =====
// Port-level checker for the relocation field patcher and its bind to the top.
// Depends on rfp_pkg and reloc_field_patcher_top.
module rfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [3:0]  mode,
    input logic [31:0] instr_word,
    input logic        done,
    input logic [31:0] patched_word,
    input logic [1:0]  status
);
    import rfp_pkg::*;

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> ##1 done)
        else $error("Accepted request produced no result two cycles later.");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, 2))
        else $error("Result shown without a matching request.");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (status == ST_OK || status == ST_UNIMPL || status == ST_UNKNOWN))
        else $error("Result status out of range.");

    a_fail_unchanged: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> patched_word == $past(instr_word, 2))
        else $error("Unsupported type changed the word.");

    a_status_mode: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mode, 2) == MODE_UNKNOWN) |-> status == ST_UNKNOWN)
        else $error("Unknown type not flagged.");

endmodule

bind reloc_field_patcher_top rfp_checker u_rfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .instr_word   (instr_word),
    .done         (done),
    .patched_word (patched_word),
    .status       (status)
);
